// File: rtl/sprc_pkg.sv
package sprc_pkg;

   // pipeline geometry
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 17;
   localparam int SQRT_BASE   = 3;
   localparam int DIV_BASE    = SQRT_BASE + SQRT_STEPS;
   localparam int TAIL_BASE   = DIV_BASE + DIV_STEPS;
   localparam int NUM_STAGES  = TAIL_BASE + 6;
   localparam int REM_W       = 50;

   localparam logic [16:0] FULL_ONE          = 17'd65536;
   localparam logic [16:0] RESTITUTION_RESET = 17'd32768;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic signed [31:0] vel_diff_x;
      logic signed [31:0] vel_diff_y;
      logic signed [31:0] vel_diff_z;
      logic [31:0]        mass_a;
      logic [31:0]        mass_b;
      logic [23:0]        radius_a;
      logic [23:0]        radius_b;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] shift_a;
      logic signed [31:0] shift_b;
      logic signed [31:0] kick_a;
      logic signed [31:0] kick_b;
   } rsp_type;

   // per-item context carried down the pipeline
   typedef struct packed {
      logic [2:0]         neg;
      logic [2:0][31:0]   mag;
      logic [2:0][31:0]   vel;
      logic [24:0]        rsum;
      logic [17:0]        f;
      logic [31:0]        mass_a;
      logic [32:0]        msum;
      logic               hit;
      logic               zero;
      logic [2:0][15:0]   norm;
      logic signed [33:0] dq;
      logic signed [31:0] shift_a;
      logic signed [31:0] shift_b;
   } ctx_type;

   // divide by 2^sh, round to nearest with ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// File: rtl/sphere_pair_collision_response_core.sv
// A result passes through 58 register stages from its input transfer to the output.
// Throughput: one sphere pair per cycle while the output is not stalled; the depth is set
// by the 32-step square root and the 17-step normal and mass-share dividers, one step per stage.
// A stalled output holds its stage; bubbles ahead of it still fill.
// Reset (synchronous): all stage valid bits clear, restitution returns to 0.5.
module sphere_pair_collision_response_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sprc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sprc_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [16:0]        csr_wdata
);

   localparam int NS   = sprc_pkg::NUM_STAGES;
   localparam int LAST = NS - 1;
   localparam int TB   = sprc_pkg::TAIL_BASE;
   localparam int DB   = sprc_pkg::DIV_BASE;
   localparam int SB   = sprc_pkg::SQRT_BASE;
   localparam int SQN  = sprc_pkg::SQRT_STEPS;
   localparam int DVN  = sprc_pkg::DIV_STEPS;
   localparam int RW   = sprc_pkg::REM_W;

   logic [16:0]        restitution_ff;
   logic [NS-1:0]      vld_ff;
   logic [NS:0]        en_w;
   sprc_pkg::ctx_type  ctx_ff [0:NS-2];
   sprc_pkg::ctx_type  ctx0_in;
   sprc_pkg::ctx_type  ctx2_in;
   sprc_pkg::ctx_type  ctxt_in;
   sprc_pkg::ctx_type  ctx4_in;
   sprc_pkg::rsp_type  rsp_ff;

   logic [63:0]        sq_ff [0:2];
   logic [49:0]        rsq_ff;
   logic [63:0]        dist2_w;
   logic [63:0]        sq_v_ff [0:SQN];
   logic [63:0]        sq_r_ff [0:SQN];

   logic [RW-1:0]      nrem_ff [0:DVN-1][0:2];
   logic [16:0]        nq_ff   [0:DVN-1][0:2];
   logic [RW-1:0]      mrem_ff [0:DVN-1];
   logic [16:0]        mq_ff   [0:DVN-1];
   logic [31:0]        dv_ff   [0:DVN-1];

   logic [16:0]        t1_wa_ff, t1_wb_ff, wa_in, wb_in;
   logic [2:0][15:0]   norm_in;
   logic signed [47:0] pv_ff [0:2];
   logic [34:0]        t2_fa_ff, t2_fb_ff;
   logic signed [49:0] vn31_ff;
   logic [17:0]        t3_ka_ff, t3_kb_ff, t4_ka_ff, t4_kb_ff;
   logic signed [35:0] vn_ff;
   logic signed [52:0] spa_ff, spb_ff;
   logic signed [54:0] kpa_ff, kpb_ff;
   logic signed [63:0] vn_in;
   logic [16:0]        e_w;
   logic               ok_w;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= sprc_pkg::RESTITUTION_RESET;
      end else if (csr_we) begin
         restitution_ff <= csr_wdata;
      end
   end

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en_w[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en_w[k] = !vld_ff[k] || en_w[k + 1];
      end
   end

   assign req_ready = en_w[0];
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = rsp_ff;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en_w[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en_w[k]) begin
               vld_ff[k] <= vld_ff[k - 1];
            end
         end
      end
   end

   // stage 0: magnitudes, radius sum, mass sum, restitution factor
   assign e_w = (restitution_ff > sprc_pkg::FULL_ONE) ? sprc_pkg::FULL_ONE : restitution_ff;

   always_comb begin
      ctx0_in        = '0;
      ctx0_in.neg[0] = req_data.offset_x[31];
      ctx0_in.neg[1] = req_data.offset_y[31];
      ctx0_in.neg[2] = req_data.offset_z[31];
      ctx0_in.mag[0] = req_data.offset_x[31] ? 32'(-req_data.offset_x) : req_data.offset_x;
      ctx0_in.mag[1] = req_data.offset_y[31] ? 32'(-req_data.offset_y) : req_data.offset_y;
      ctx0_in.mag[2] = req_data.offset_z[31] ? 32'(-req_data.offset_z) : req_data.offset_z;
      ctx0_in.vel[0] = req_data.vel_diff_x;
      ctx0_in.vel[1] = req_data.vel_diff_y;
      ctx0_in.vel[2] = req_data.vel_diff_z;
      ctx0_in.rsum   = 25'(req_data.radius_a) + 25'(req_data.radius_b);
      ctx0_in.f      = 18'(sprc_pkg::FULL_ONE) + 18'(e_w);
      ctx0_in.mass_a = req_data.mass_a;
      ctx0_in.msum   = 33'(req_data.mass_a) + 33'(req_data.mass_b);
   end

   always_ff @(posedge clock) begin
      if (en_w[0]) begin
         ctx_ff[0] <= ctx0_in;
      end
   end

   // stage 1: squares
   always_ff @(posedge clock) begin
      if (en_w[1]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 64'(ctx_ff[0].mag[i]) * 64'(ctx_ff[0].mag[i]);
         end
         rsq_ff    <= 50'(ctx_ff[0].rsum) * 50'(ctx_ff[0].rsum);
         ctx_ff[1] <= ctx_ff[0];
      end
   end

   // stage 2: squared distance, contact test, root operand
   assign dist2_w = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_comb begin
      ctx2_in      = ctx_ff[1];
      ctx2_in.hit  = dist2_w < 64'(rsq_ff);
      ctx2_in.zero = dist2_w == 64'd0;
   end

   always_ff @(posedge clock) begin
      if (en_w[2]) begin
         ctx_ff[2]  <= ctx2_in;
         sq_v_ff[0] <= dist2_w << 14;
         sq_r_ff[0] <= '0;
      end
   end

   // context copy through root and divider stages
   for (genvar k = SB; k < TB; k++) begin : g_ctx
      always_ff @(posedge clock) begin
         if (en_w[k]) begin
            ctx_ff[k] <= ctx_ff[k - 1];
         end
      end
   end

   // square root: one result bit per stage
   for (genvar k = 0; k < SQN; k++) begin : g_sqrt
      localparam logic [63:0] BitVal = 64'd1 << (62 - 2 * k);
      logic [63:0] trial_w;
      assign trial_w = sq_r_ff[k] + BitVal;
      always_ff @(posedge clock) begin
         if (en_w[SB + k]) begin
            if (sq_v_ff[k] >= trial_w) begin
               sq_v_ff[k + 1] <= sq_v_ff[k] - trial_w;
               sq_r_ff[k + 1] <= (sq_r_ff[k] >> 1) + BitVal;
            end else begin
               sq_v_ff[k + 1] <= sq_v_ff[k];
               sq_r_ff[k + 1] <= sq_r_ff[k] >> 1;
            end
         end
      end
   end

   // restoring dividers: three normal components and the mass share
   for (genvar j = 0; j < DVN; j++) begin : g_div
      localparam int Sh = DVN - 1 - j;
      logic [RW-1:0] rin_w [0:2];
      logic [16:0]   qin_w [0:2];
      logic [RW-1:0] mrin_w;
      logic [16:0]   mqin_w;
      logic [31:0]   dvin_w;
      logic [RW-1:0] dsh_w, msh_w;

      if (j == 0) begin : g_first
         logic [31:0] dq_w;
         assign dq_w   = sq_r_ff[SQN][31:0];
         assign dvin_w = dq_w;
         for (genvar i = 0; i < 3; i++) begin : g_num
            assign rin_w[i] = RW'({ctx_ff[DB - 1].mag[i][24:0], 22'd0}) + RW'(dq_w >> 1);
            assign qin_w[i] = '0;
         end
         assign mrin_w = RW'({ctx_ff[DB - 1].mass_a, 16'd0}) + RW'(ctx_ff[DB - 1].msum >> 1);
         assign mqin_w = '0;
      end else begin : g_next
         assign dvin_w = dv_ff[j - 1];
         for (genvar i = 0; i < 3; i++) begin : g_num
            assign rin_w[i] = nrem_ff[j - 1][i];
            assign qin_w[i] = nq_ff[j - 1][i];
         end
         assign mrin_w = mrem_ff[j - 1];
         assign mqin_w = mq_ff[j - 1];
      end

      assign dsh_w = RW'(dvin_w) << Sh;
      assign msh_w = RW'(ctx_ff[DB + j - 1].msum) << Sh;

      always_ff @(posedge clock) begin
         if (en_w[DB + j]) begin
            dv_ff[j] <= dvin_w;
            for (int i = 0; i < 3; i++) begin
               if (rin_w[i] >= dsh_w) begin
                  nrem_ff[j][i] <= rin_w[i] - dsh_w;
                  nq_ff[j][i]   <= qin_w[i] | (17'd1 << Sh);
               end else begin
                  nrem_ff[j][i] <= rin_w[i];
                  nq_ff[j][i]   <= qin_w[i];
               end
            end
            if (mrin_w >= msh_w) begin
               mrem_ff[j] <= mrin_w - msh_w;
               mq_ff[j]   <= mqin_w | (17'd1 << Sh);
            end else begin
               mrem_ff[j] <= mrin_w;
               mq_ff[j]   <= mqin_w;
            end
         end
      end
   end

   // tail 1: clamp normals, mass shares, penetration depth
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (ctx_ff[TB - 1].neg[i]) begin
            norm_in[i] = (nq_ff[DVN - 1][i] > 17'd32768) ? 16'h8000
                                                          : 16'(17'd0 - nq_ff[DVN - 1][i]);
         end else begin
            norm_in[i] = (nq_ff[DVN - 1][i] > 17'd32767) ? 16'h7FFF
                                                          : nq_ff[DVN - 1][i][15:0];
         end
      end
      // both masses zero leaves both shares zero
      if (ctx_ff[TB - 1].msum == 33'd0) begin
         wa_in = 17'd0;
         wb_in = 17'd0;
      end else begin
         wa_in = mq_ff[DVN - 1];
         wb_in = sprc_pkg::FULL_ONE - mq_ff[DVN - 1];
      end
      ctxt_in      = ctx_ff[TB - 1];
      ctxt_in.norm = norm_in;
      ctxt_in.dq   = $signed(34'(dv_ff[DVN - 1]))
                   - $signed(34'({ctx_ff[TB - 1].rsum, 7'd0}));
   end

   always_ff @(posedge clock) begin
      if (en_w[TB]) begin
         ctx_ff[TB] <= ctxt_in;
         t1_wa_ff   <= wa_in;
         t1_wb_ff   <= wb_in;
      end
   end

   // tail 2: velocity products, restitution times shares
   always_ff @(posedge clock) begin
      if (en_w[TB + 1]) begin
         ctx_ff[TB + 1] <= ctx_ff[TB];
         for (int i = 0; i < 3; i++) begin
            pv_ff[i] <= $signed(ctx_ff[TB].vel[i]) * $signed(ctx_ff[TB].norm[i]);
         end
         t2_fa_ff <= 35'(ctx_ff[TB].f) * 35'(t1_wa_ff);
         t2_fb_ff <= 35'(ctx_ff[TB].f) * 35'(t1_wb_ff);
      end
   end

   // tail 3: normal velocity sum, rounded factors
   always_ff @(posedge clock) begin
      if (en_w[TB + 2]) begin
         ctx_ff[TB + 2] <= ctx_ff[TB + 1];
         vn31_ff  <= 50'(pv_ff[0]) + 50'(pv_ff[1]) + 50'(pv_ff[2]);
         t3_ka_ff <= 18'((t2_fa_ff + 35'd32768) >> 16);
         t3_kb_ff <= 18'((t2_fb_ff + 35'd32768) >> 16);
      end
   end

   // tail 4: round normal velocity, position products
   assign vn_in = sprc_pkg::round_shift({{14{vn31_ff[49]}}, vn31_ff}, 15);

   always_ff @(posedge clock) begin
      if (en_w[TB + 3]) begin
         ctx_ff[TB + 3] <= ctx_ff[TB + 2];
         vn_ff    <= vn_in[35:0];
         spa_ff   <= ctx_ff[TB + 2].dq * $signed({1'b0, t3_ka_ff});
         spb_ff   <= ctx_ff[TB + 2].dq * $signed({1'b0, t3_kb_ff});
         t4_ka_ff <= t3_ka_ff;
         t4_kb_ff <= t3_kb_ff;
      end
   end

   // tail 5: velocity products, finish position corrections
   always_comb begin
      ctx4_in         = ctx_ff[TB + 3];
      ctx4_in.shift_a = sprc_pkg::sat32(
         sprc_pkg::round_shift({{11{spa_ff[52]}}, spa_ff}, 23));
      ctx4_in.shift_b = sprc_pkg::sat32(
         -sprc_pkg::round_shift({{11{spb_ff[52]}}, spb_ff}, 23));
   end

   always_ff @(posedge clock) begin
      if (en_w[TB + 4]) begin
         ctx_ff[TB + 4] <= ctx4_in;
         kpa_ff <= vn_ff * $signed({1'b0, t4_kb_ff});
         kpb_ff <= vn_ff * $signed({1'b0, t4_ka_ff});
      end
   end

   // output register: finish kicks, zero normals and corrections without a usable normal
   assign ok_w = ctx_ff[TB + 4].hit && !ctx_ff[TB + 4].zero;

   always_ff @(posedge clock) begin
      if (en_w[LAST]) begin
         rsp_ff.hit        <= ctx_ff[TB + 4].hit;
         rsp_ff.normal_x   <= ok_w ? ctx_ff[TB + 4].norm[0] : '0;
         rsp_ff.normal_y   <= ok_w ? ctx_ff[TB + 4].norm[1] : '0;
         rsp_ff.normal_z   <= ok_w ? ctx_ff[TB + 4].norm[2] : '0;
         rsp_ff.shift_a    <= ok_w ? ctx_ff[TB + 4].shift_a : '0;
         rsp_ff.shift_b    <= ok_w ? ctx_ff[TB + 4].shift_b : '0;
         rsp_ff.kick_a     <= ok_w ? sprc_pkg::sat32(
            sprc_pkg::round_shift({{9{kpa_ff[54]}}, kpa_ff}, 16)) : '0;
         rsp_ff.kick_b     <= ok_w ? sprc_pkg::sat32(
            -sprc_pkg::round_shift({{9{kpb_ff[54]}}, kpb_ff}, 16)) : '0;
      end
   end

   // no contact means all corrections are zero
   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.shift_a == '0 && rsp_data.shift_b == '0
         && rsp_data.kick_a == '0 && rsp_data.kick_b == '0 && rsp_data.normal_x == '0)
      else $error("nonzero correction without contact");

   // an input transfer lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted pair lost at entry");

   // a stalled output keeps the stage behind it occupied
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !rsp_ready && vld_ff[LAST - 1] |=> vld_ff[LAST - 1] && vld_ff[LAST])
      else $error("stalled pipeline dropped an item");

   // configuration write takes effect
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> restitution_ff == $past(csr_wdata))
      else $error("restitution write lost");

endmodule
